// ===== hw/rtl/fwrc_pkg.sv =====
// shared types, constants and the crc-8 step for the framed word receiver
// no dependencies; imported by every module of the block but fwrc_ram
package fwrc_pkg;

    localparam int MAX_WORDS = 15;
    localparam int WIDX_W    = 4;
    localparam int LEN_W     = 4;
    localparam int ID_W      = 4;
    localparam int WORD_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEN_W:0] MAX_WORDS_V = (LEN_W + 1)'(MAX_WORDS);

    localparam int RAM_DEPTH = 2 ** (WIDX_W + 1);
    localparam int RAM_AW    = WIDX_W + 1;

    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    localparam logic [BYTE_W-1:0] CRC_POLY       = 8'h31;
    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd165;
    localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'd88;

    localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_EN = 2'd2;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_CRC   = 2'd1,
        KIND_END   = 2'd2,
        KIND_EMPTY = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HEADER,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_WAIT,
        BK_STATUS
    } bstate_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
        logic              crc_en;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic              bank;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

    function automatic logic [BYTE_W-1:0] crc8_step(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[BYTE_W-1])
            begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/framed_word_receiver_crc8_core.sv =====
// top level of the framed word receiver with crc-8 check
// depends on fwrc_pkg, fwrc_front, fwrc_cmd_fifo, fwrc_back and fwrc_ram
//
// input channel: one received byte per word on rx_byte, taken when in_valid
// is high and in_stall low. the parser normally takes a byte every cycle; it
// stalls only at a payload byte while the target buffer bank is still being
// drained, or at the end byte while the command queue (two frames) is full.
// output channel: one result word per handshake on kind, frame_id,
// word_index, data_word and last, taken when out_valid is high and out_stall
// low. a finished frame is registered in the command queue, then popped by
// the back end; a status result follows from its status state, and each data
// word from a read state and a wait state, set by the registered payload read.
// a stalled result holds while the parser keeps taking bytes; the queue holds
// two finished frames behind the one being sent, and payload bytes stall
// once both buffer banks hold words not yet sent.
// configuration: cfg_index selects start byte, end byte or crc enable and
// cfg_data carries the value; cfg_ready is always high.
// reset sets start byte 165, end byte 88, crc check off, and leaves the
// parser waiting for a start byte with no results pending.
module framed_word_receiver_crc8_core
    import fwrc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           kind,
    output logic [ID_W-1:0]      frame_id,
    output logic [WIDX_W-1:0]    word_index,
    output logic [WORD_W-1:0]    data_word,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    cfg_t                cfg_reg, cfg_next;
    logic                push;
    cmd_t                push_cmd;
    logic                pop;
    cmd_t                head;
    logic                fifo_full;
    logic                fifo_empty;
    release_t            rel;
    logic                ram_wr_en;
    logic [RAM_AW-1:0]   ram_wr_addr;
    logic [WORD_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [RAM_AW-1:0]   ram_rd_addr;
    logic [WORD_W-1:0]   ram_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{start_byte: START_BYTE_RST, end_byte: END_BYTE_RST, crc_en: 1'b0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_START:  cfg_next.start_byte = cfg_data;
                CFG_END:    cfg_next.end_byte   = cfg_data;
                CFG_CRC_EN: cfg_next.crc_en     = cfg_data[0];
                default:    cfg_next            = cfg_reg;
            endcase
        end
    end

    fwrc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .push        (push),
        .push_cmd    (push_cmd),
        .fifo_full   (fifo_full),
        .rel         (rel),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data)
    );

    fwrc_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    fwrc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    fwrc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_empty  (fifo_empty),
        .head        (head),
        .pop         (pop),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .rel         (rel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .frame_id    (frame_id),
        .word_index  (word_index),
        .data_word   (data_word),
        .last        (last)
    );

endmodule

// ===== hw/rtl/fwrc_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module fwrc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/fwrc_front.sv =====
// front end: frame parser, crc-8 accumulation and payload buffer writes
// depends on fwrc_pkg; feeds fwrc_cmd_fifo and the payload ram
module fwrc_front
    import fwrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  rx_byte,
    output logic               push,
    output cmd_t               push_cmd,
    input  logic               fifo_full,
    input  release_t           rel,
    output logic               ram_wr_en,
    output logic [RAM_AW-1:0]  ram_wr_addr,
    output logic [WORD_W-1:0]  ram_wr_data
);

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [BYTE_W-1:0]  crc_reg, crc_next;
    logic               match_reg, match_next;
    logic [BYTE_W-1:0]  hi_reg, hi_next;
    logic               bank_reg, bank_next;
    logic [1:0]         busy_reg, busy_next;

    logic [COUNT_W-1:0] data_end;
    logic [COUNT_W-1:0] count_m2;
    logic               in_data;
    logic               at_crc;
    logic               accept;
    kind_t              end_kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            count_reg <= '0;
            len_reg   <= '0;
            id_reg    <= '0;
            crc_reg   <= '0;
            match_reg <= 1'b0;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            id_reg    <= id_next;
            crc_reg   <= crc_next;
            match_reg <= match_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
    end

    always_comb
    begin
        data_end = {1'b0, len_reg, 1'b0} + COUNT_W'(2);
        count_m2 = count_reg - COUNT_W'(2);
        in_data  = count_reg < data_end;
        at_crc   = count_reg == data_end;

        in_stall = (phase_reg == PH_BODY)
                   && ((in_data && count_reg[0] && busy_reg[bank_reg])
                       || (!in_data && !at_crc && fifo_full));
        accept = in_valid && !in_stall;

        priority if (rx_byte != cfg.end_byte)
        begin
            end_kind = KIND_END;
        end
        else if (cfg.crc_en && !match_reg)
        begin
            end_kind = KIND_CRC;
        end
        else if (len_reg == '0)
        begin
            end_kind = KIND_EMPTY;
        end
        else
        begin
            end_kind = KIND_DATA;
        end

        phase_next  = phase_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        id_next     = id_reg;
        crc_next    = crc_reg;
        match_next  = match_reg;
        hi_next     = hi_reg;
        bank_next   = bank_reg;
        busy_next   = busy_reg;
        push        = 1'b0;
        push_cmd    = '{kind: end_kind, id: id_reg, len: len_reg, bank: bank_reg};
        ram_wr_en   = 1'b0;
        ram_wr_addr = {bank_reg, count_m2[WIDX_W:1]};
        ram_wr_data = {hi_reg, rx_byte};

        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end

        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    len_next = rx_byte[7:4];
                    id_next  = rx_byte[3:0];
                    if ({1'b0, rx_byte[7:4]} > MAX_WORDS_V)
                    begin
                        phase_next = PH_WAIT;
                        count_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                        crc_next   = crc8_step('0, rx_byte);
                        match_next = 1'b0;
                        count_next = COUNT_W'(2);
                    end
                end
                PH_BODY:
                begin
                    priority if (in_data)
                    begin
                        crc_next   = crc8_step(crc_reg, rx_byte);
                        count_next = count_reg + COUNT_W'(1);
                        if (!count_reg[0])
                        begin
                            hi_next = rx_byte;
                        end
                        else
                        begin
                            ram_wr_en = 1'b1;
                        end
                    end
                    else if (at_crc)
                    begin
                        match_next = rx_byte == crc_reg;
                        count_next = count_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        push       = 1'b1;
                        phase_next = PH_WAIT;
                        count_next = '0;
                        if (end_kind == KIND_DATA)
                        begin
                            busy_next[bank_reg] = 1'b1;
                            bank_next           = ~bank_reg;
                        end
                    end
                end
                default:
                begin
                    if (rx_byte == cfg.start_byte)
                    begin
                        phase_next = PH_HEADER;
                        count_next = COUNT_W'(1);
                        crc_next   = '0;
                        match_next = 1'b0;
                    end
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push && push_cmd.kind == KIND_DATA |-> !busy_reg[bank_reg])
        else $error("frame handed over on a bank still being drained");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> !busy_reg[bank_reg] && phase_reg == PH_BODY)
        else $error("payload write into a bank owned by the back end");

endmodule

// ===== hw/rtl/fwrc_cmd_fifo.sv =====
// short queue of frame commands between the parser and the result sequencer
// depends on fwrc_pkg
module fwrc_cmd_fifo
    import fwrc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    cmd_t                 entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_PTR_W:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_comb
    begin
        full        = cnt_reg == (CMD_PTR_W + 1)'(CMD_DEPTH);
        empty       = cnt_reg == '0;
        head        = entry_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + CMD_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + CMD_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (CMD_PTR_W + 1)'(push) - (CMD_PTR_W + 1)'(pop);
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("command pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("command popped from an empty queue");

endmodule

// ===== hw/rtl/fwrc_back.sv =====
// back end: turns frame commands into result words, reading the payload ram
// depends on fwrc_pkg; fed by fwrc_cmd_fifo
module fwrc_back
    import fwrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fifo_empty,
    input  cmd_t               head,
    output logic               pop,
    output logic               ram_rd_en,
    output logic [RAM_AW-1:0]  ram_rd_addr,
    input  logic [WORD_W-1:0]  ram_rd_data,
    output release_t           rel,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [ID_W-1:0]    frame_id,
    output logic [WIDX_W-1:0]  word_index,
    output logic [WORD_W-1:0]  data_word,
    output logic               last
);

    bstate_t             state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [WIDX_W-1:0]   idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    kind_t               kind_reg, kind_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [WIDX_W-1:0]   windex_reg, windex_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic                last_reg, last_next;
    logic                slot_free;
    logic                is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        kind_reg   <= kind_next;
        id_reg     <= id_next;
        windex_reg <= windex_next;
        word_reg   <= word_next;
        last_reg   <= last_next;
    end

    always_comb
    begin
        slot_free   = !out_valid_reg || !out_stall;
        is_last     = idx_reg == (cmd_reg.len - LEN_W'(1));
        ram_rd_addr = {cmd_reg.bank, idx_reg};

        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        id_next        = id_reg;
        windex_next    = windex_reg;
        word_next      = word_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        ram_rd_en      = 1'b0;
        rel            = '{valid: 1'b0, bank: cmd_reg.bank};

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = head;
                    idx_next   = '0;
                    state_next = (head.kind == KIND_DATA) ? BK_READ : BK_STATUS;
                end
            end
            BK_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = BK_WAIT;
            end
            BK_WAIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_DATA;
                    id_next        = cmd_reg.id;
                    windex_next    = idx_reg;
                    word_next      = ram_rd_data;
                    last_next      = is_last;
                    if (is_last)
                    begin
                        rel.valid  = 1'b1;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + WIDX_W'(1);
                        state_next = BK_READ;
                    end
                end
            end
            BK_STATUS:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = cmd_reg.kind;
                    id_next        = cmd_reg.id;
                    windex_next    = '0;
                    word_next      = '0;
                    last_next      = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign frame_id   = id_reg;
    assign word_index = windex_reg;
    assign data_word  = word_reg;
    assign last       = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != KIND_DATA |-> last_reg && word_reg == '0)
        else $error("status result without last or with a nonzero word");

    assert property (@(posedge clk) disable iff (!rst_n)
        rel.valid |-> state_reg == BK_WAIT && slot_free)
        else $error("bank released before its last word was loaded");

endmodule

// ===== dv/fwrc_frame_board_pkg.sv =====
// frame-level prediction of the framed word receiver and the queue of results it expects
// depends on fwrc_pkg for result kinds, parser phases and register indexes
package fwrc_frame_board_pkg;

    import fwrc_pkg::*;

    typedef struct packed {
        kind_t        kind;
        logic [3:0]   id;
        logic [3:0]   index;
        logic [15:0]  data;
        logic         last;
    } frame_result_t;

    class frame_board;

        frame_result_t pending_results[$];
        int            errors;

        logic [7:0]    start_val;
        logic [7:0]    end_val;
        logic          crc_on;

        phase_t        ph;
        int            pos;
        logic [3:0]    len;
        logic [3:0]    id;
        logic [7:0]    crc;
        logic          crc_ok;
        logic [15:0]   words [15];

        function new();
            errors    = 0;
            start_val = 8'd165;
            end_val   = 8'd88;
            crc_on    = 1'b0;
            ph        = PH_WAIT;
            pos       = 0;
            len       = '0;
            id        = '0;
            crc       = '0;
            crc_ok    = 1'b0;
            foreach (words[i])
            begin
                words[i] = '0;
            end
        endfunction

        static function logic [7:0] crc_next(input logic [7:0] c, input logic [7:0] b);
            logic [7:0] r;
            r = c ^ b;
            repeat (8)
            begin
                r = r[7] ? ({r[6:0], 1'b0} ^ 8'h31) : {r[6:0], 1'b0};
            end
            return r;
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [7:0] val);
            if (idx == CFG_START)
            begin
                start_val = val;
            end
            else if (idx == CFG_END)
            begin
                end_val = val;
            end
            else if (idx == CFG_CRC_EN)
            begin
                crc_on = val[0];
            end
        endfunction

        function bit waiting();
            return ph != PH_HEADER && ph != PH_BODY;
        endfunction

        function void push_result(input kind_t k, input int idx, input logic [15:0] d,
                                  input logic l);
            frame_result_t r;
            r.kind  = k;
            r.id    = id;
            r.index = idx[3:0];
            r.data  = d;
            r.last  = l;
            pending_results.push_back(r);
        endfunction

        function void note_byte(input logic [7:0] b);
            int span;
            int w;
            span = 2 * int'(len) + 2;
            if (ph == PH_HEADER)
            begin
                len    = b[7:4];
                id     = b[3:0];
                crc    = crc_next(8'h00, b);
                crc_ok = 1'b0;
                pos    = 2;
                ph     = PH_BODY;
            end
            else if (ph == PH_BODY)
            begin
                if (pos < span)
                begin
                    crc = crc_next(crc, b);
                    w   = (pos - 2) >> 1;
                    if (pos % 2 == 0)
                    begin
                        words[w] = {b, 8'h00};
                    end
                    else
                    begin
                        words[w][7:0] = b;
                    end
                    pos++;
                end
                else if (pos == span)
                begin
                    crc_ok = (b == crc);
                    pos++;
                end
                else
                begin
                    if (b != end_val)
                    begin
                        push_result(KIND_END, 0, 16'h0000, 1'b1);
                    end
                    else if (crc_on && !crc_ok)
                    begin
                        push_result(KIND_CRC, 0, 16'h0000, 1'b1);
                    end
                    else if (len == 0)
                    begin
                        push_result(KIND_EMPTY, 0, 16'h0000, 1'b1);
                    end
                    else
                    begin
                        for (int i = 0; i < int'(len); i++)
                        begin
                            push_result(KIND_DATA, i, words[i], i + 1 == int'(len));
                        end
                    end
                    ph  = PH_WAIT;
                    pos = 0;
                end
            end
            else if (b == start_val)
            begin
                ph     = PH_HEADER;
                pos    = 1;
                crc    = '0;
                crc_ok = 1'b0;
            end
        endfunction

        function void check_result(input frame_result_t got);
            frame_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected result: kind %0d id %0d index %0d word %h last %0d",
                             got.kind, got.id, got.index, got.data, got.last);
                end
                return;
            end
            want = pending_results.pop_front();
            if (got != want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("result mismatch: expected kind %0d id %0d index %0d word %h last %0d",
                             want.kind, want.id, want.index, want.data, want.last);
                    $display("                 got      kind %0d id %0d index %0d word %h last %0d",
                             got.kind, got.id, got.index, got.data, got.last);
                end
            end
        endfunction

        function void close_out();
            if (pending_results.size() != 0)
            begin
                errors += pending_results.size();
                if (errors <= 10)
                begin
                    $display("%0d results never arrived", pending_results.size());
                end
            end
        endfunction

    endclass

endpackage

// ===== dv/framed_word_receiver_crc8_core_test.sv =====
// testbench for framed_word_receiver_crc8_core: directed and random frames under random stalls
// depends on fwrc_pkg and fwrc_frame_board_pkg; beyond these needs only the rtl of the block
module framed_word_receiver_crc8_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fwrc_pkg::*;
    import fwrc_frame_board_pkg::*;

    typedef enum int {
        FLAW_NONE,
        FLAW_CRC,
        FLAW_END,
        FLAW_CUT
    } flaw_t;

    localparam int FILL_RANDOM = -1;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [BYTE_W-1:0]    rx_byte   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           kind;
    logic [ID_W-1:0]      frame_id;
    logic [WIDX_W-1:0]    word_index;
    logic [WORD_W-1:0]    data_word;
    logic                 last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data  = '0;

    frame_board board;
    bit         steady     = 1'b0;
    int         bytes_sent = 0;

    framed_word_receiver_crc8_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .frame_id   (frame_id),
        .word_index (word_index),
        .data_word  (data_word),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= !steady && ($urandom_range(99) < 31);
    end

    always @(posedge clk)
    begin
        frame_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.kind  = kind_t'(kind);
            got.id    = frame_id;
            got.index = word_index;
            got.data  = data_word;
            got.last  = last;
            board.check_result(got);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        board.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input int n, input logic [3:0] id, input flaw_t flaw,
                              input int fill);
        logic [7:0]  q[$];
        logic [7:0]  crc;
        logic [7:0]  hdr;
        logic [15:0] w;
        int          keep;
        hdr = {n[3:0], id};
        q.push_back(board.start_val);
        q.push_back(hdr);
        crc = frame_board::crc_next(8'h00, hdr);
        for (int i = 0; i < n; i++)
        begin
            if (fill >= 0)
            begin
                w = fill[15:0];
            end
            else
            begin
                case ($urandom_range(7))
                    0:       w = 16'h0000;
                    1:       w = 16'hffff;
                    default: w = 16'($urandom);
                endcase
            end
            q.push_back(w[15:8]);
            q.push_back(w[7:0]);
            crc = frame_board::crc_next(crc, w[15:8]);
            crc = frame_board::crc_next(crc, w[7:0]);
        end
        if (flaw == FLAW_CRC)
        begin
            crc ^= 8'($urandom_range(1, 255));
        end
        q.push_back(crc);
        if (flaw == FLAW_END)
        begin
            q.push_back(board.end_val ^ 8'($urandom_range(1, 255)));
        end
        else
        begin
            q.push_back(board.end_val);
        end
        keep = (flaw == FLAW_CUT) ? $urandom_range(1, q.size() - 2) : q.size();
        for (int i = 0; i < keep; i++)
        begin
            send_byte(q[i]);
        end
    endtask

    task automatic random_traffic(input int budget, input bit lead_full);
        int    stop;
        int    pick;
        int    n;
        flaw_t flaw;
        stop = bytes_sent + budget;
        if (lead_full)
        begin
            send_frame(15, 4'($urandom), FLAW_NONE, FILL_RANDOM);
        end
        while (bytes_sent < stop)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    send_byte(8'($urandom));
                end
            end
            else
            begin
                flaw = (pick < 18) ? FLAW_CRC : (pick < 28) ? FLAW_END :
                       (pick < 36) ? FLAW_CUT : FLAW_NONE;
                n = ($urandom_range(9) == 0) ? 15 : $urandom_range(0, 4);
                send_frame(n, 4'($urandom), flaw, FILL_RANDOM);
            end
        end
    endtask

    task automatic settle();
        while (!board.waiting())
        begin
            send_byte(8'h00);
        end
        in_valid <= 1'b0;
        while (board.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        board.write_reg(idx, val);
    endtask

    task automatic configure(input logic [7:0] s, input logic [7:0] e, input logic c);
        settle();
        write_reg(CFG_START, s);
        write_reg(CFG_END, e);
        write_reg(CFG_CRC_EN, {7'b0, c});
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        board = new();
        repeat (4)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: noise, empty frame, wrong end with start byte as data, bad crc ignored
        send_byte(8'h00);
        send_byte(8'hff);
        send_frame(0, 4'h0, FLAW_NONE, 0);
        send_frame(1, 4'hf, FLAW_END, 16'ha5a5);
        send_frame(2, 4'h9, FLAW_CRC, 16'hffff);
        random_traffic(25, 1'b0);

        configure(8'h00, 8'hff, 1'b1);
        send_frame(1, 4'h6, FLAW_CRC, 16'h0000);
        random_traffic(36, 1'b1);

        steady = 1'b1;
        configure(8'hff, 8'h00, 1'b0);
        random_traffic(25, 1'b0);
        steady = 1'b0;

        configure(8'($urandom), 8'($urandom), 1'b1);
        random_traffic(36, 1'b1);

        configure(8'd165, 8'd88, 1'b1);
        random_traffic(10, 1'b0);

        settle();
        board.close_out();
        if (board.errors == 0)
        begin
            $display("framed_word_receiver_crc8_core verification clean");
        end
        else
        begin
            $display("framed_word_receiver_crc8_core verification failed");
        end
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("framed_word_receiver_crc8_core verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/fwrc_pkg.sv
hw/rtl/fwrc_ram.sv
hw/rtl/fwrc_front.sv
hw/rtl/fwrc_cmd_fifo.sv
hw/rtl/fwrc_back.sv
hw/rtl/framed_word_receiver_crc8_core.sv
dv/fwrc_frame_board_pkg.sv
dv/framed_word_receiver_crc8_core_test.sv
